// ===== rtl/core/ptc_pkg.sv =====
package ptc_pkg;

  // CORDIC x/y datapath: Q1.30 with headroom for the CORDIC gain.
  localparam int unsigned XW = 34;
  // Residual angle: Q1.31 of pi, one bit wider to hold the folded range.
  localparam int unsigned ZW = 33;
  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned ATAN_STEPS = 30;

  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] FULL_PI = ZW'(64'sd2147483648);

  // round(atan(2^-i) / pi * 2^31)
  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_STEPS] = '{
    ZW'(536870912), ZW'(316933406), ZW'(167458907), ZW'(85004756), ZW'(42667331),
    ZW'(21354465), ZW'(10679838), ZW'(5340245), ZW'(2670163), ZW'(1335087),
    ZW'(667544), ZW'(333772), ZW'(166886), ZW'(83443), ZW'(41722),
    ZW'(20861), ZW'(10430), ZW'(5215), ZW'(2608), ZW'(1304),
    ZW'(652), ZW'(326), ZW'(163), ZW'(81), ZW'(41),
    ZW'(20), ZW'(10), ZW'(5), ZW'(3), ZW'(1)
  };

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic func;
    logic neg;
  } ctl_t;

endpackage

// ===== rtl/core/ptc_cell.sv =====
module ptc_cell #(
  parameter int unsigned STEP = 0,
  parameter int unsigned SW   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ptc_pkg::ctl_t                     ctl_i,
  input  logic signed [ptc_pkg::XW-1:0]     x_i,
  input  logic signed [ptc_pkg::XW-1:0]     y_i,
  input  logic signed [ptc_pkg::ZW-1:0]     z_i,
  input  logic signed [SW-1:0]              a_i,
  input  logic signed [SW-1:0]              b_i,
  output ptc_pkg::ctl_t                     ctl_o,
  output logic signed [ptc_pkg::XW-1:0]     x_o,
  output logic signed [ptc_pkg::XW-1:0]     y_o,
  output logic signed [ptc_pkg::ZW-1:0]     z_o,
  output logic signed [SW-1:0]              a_o,
  output logic signed [SW-1:0]              b_o
);
  import ptc_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = ATAN_TAB[STEP];

  ctl_t                   ctl_q;
  logic signed [XW-1:0]   x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]   z_q, z_d;
  logic signed [SW-1:0]   a_q, b_q;
  logic signed [XW-1:0]   dx, dy;

  // One micro-rotation; the direction follows the sign of the residual angle.
  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    a_q <= a_i;
    b_q <= b_i;
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign a_o   = a_q;
  assign b_o   = b_q;

endmodule

// ===== rtl/core/ptc_mix.sv =====
module ptc_mix #(
  parameter int unsigned SW = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptc_pkg::ctl_t                 ctl_i,
  input  logic signed [ptc_pkg::XW-1:0] cos_i,
  input  logic signed [ptc_pkg::XW-1:0] sin_i,
  input  logic signed [SW-1:0]          a_i,
  input  logic signed [SW-1:0]          b_i,
  output logic                          done_o,
  output logic signed [SW-1:0]          out_a_o,
  output logic signed [SW-1:0]          out_b_o,
  output logic                          clipped_o
);
  import ptc_pkg::*;

  localparam int unsigned PW   = SW + XW;
  localparam int unsigned SUMW = PW + 1;
  localparam int unsigned RW   = SUMW - FRAC_BITS;
  localparam logic signed [SUMW-1:0] RND   = SUMW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [RW-1:0]   R_MAX = RW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0]   R_MIN = -R_MAX - RW'(1);

  ctl_t                   ctl_q;
  logic signed [PW-1:0]   ac_q, bs_q, bc_q, as_q;
  logic signed [SUMW-1:0] sum_a, sum_b;
  logic signed [RW-1:0]   r_a, r_b;
  logic signed [SW-1:0]   sat_a, sat_b;
  logic                   clip_a, clip_b;
  logic                   done_q, clipped_q;
  logic signed [SW-1:0]   out_a_q, out_b_q;

  // Stage 1: four products, registered.
  always_ff @(posedge clk_i) begin
    ac_q <= PW'(a_i * cos_i);
    bs_q <= PW'(b_i * sin_i);
    bc_q <= PW'(b_i * cos_i);
    as_q <= PW'(a_i * sin_i);
  end

  // Stage 2: combine, undo the fold, round and clamp.
  always_comb begin
    if (!ctl_q.func) begin
      sum_a = SUMW'(ac_q) + SUMW'(bs_q);
      sum_b = SUMW'(bc_q) - SUMW'(as_q);
    end else begin
      sum_a = SUMW'(ac_q) - SUMW'(bs_q);
      sum_b = SUMW'(as_q) + SUMW'(bc_q);
    end
    if (ctl_q.neg) begin
      sum_a = -sum_a;
      sum_b = -sum_b;
    end
    r_a = RW'((sum_a + RND) >>> FRAC_BITS);
    r_b = RW'((sum_b + RND) >>> FRAC_BITS);
    clip_a = 1'b1;
    clip_b = 1'b1;
    priority if (r_a > R_MAX) begin
      sat_a = SW'(R_MAX);
    end else if (r_a < R_MIN) begin
      sat_a = SW'(R_MIN);
    end else begin
      sat_a  = SW'(r_a);
      clip_a = 1'b0;
    end
    priority if (r_b > R_MAX) begin
      sat_b = SW'(R_MAX);
    end else if (r_b < R_MIN) begin
      sat_b = SW'(R_MIN);
    end else begin
      sat_b  = SW'(r_b);
      clip_b = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ctl_q  <= ctl_i;
      done_q <= ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_a_q   <= sat_a;
    out_b_q   <= sat_b;
    clipped_q <= clip_a | clip_b;
  end

  assign done_o    = done_q;
  assign out_a_o   = out_a_q;
  assign out_b_o   = out_b_q;
  assign clipped_o = clipped_q;

endmodule

// ===== rtl/core/park_transform_cordic_unit.sv =====
// Throughput: one transfer per cycle; busy_o stays low since every stage advances each cycle.
// The stall-free pipeline is one fold stage, ITERATIONS CORDIC cells, a product stage and
// a round/clamp stage; the receiver cannot stall, so no stage ever holds.
// Reset (rst_ni low, asynchronous) drops every item in flight; datapath registers keep
// whatever they hold and only the control bits (valid, func, neg) and done clear.
module park_transform_cordic_unit #(
  parameter int unsigned ITERATIONS   = 24,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           func_i,
  input  logic signed [31:0]             angle_i,
  input  logic signed [SAMPLE_WIDTH-1:0] comp_a_i,
  input  logic signed [SAMPLE_WIDTH-1:0] comp_b_i,
  output logic                           done_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_a_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_b_o,
  output logic                           clipped_o
);
  import ptc_pkg::*;

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned LAT = ITERATIONS + 3;

  // The pipeline never stalls, so a new transfer is taken every cycle.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Fold stage: bring the angle into [-pi/2, pi/2]. A fold by pi flips the sign
  // of both sine and cosine; carry that as a flag and apply it after the products.
  // The exact values +-pi/2 stay unfolded; -pi folds to zero.
  // ---------------------------------------------------------------------------
  ctl_t                 fold_ctl_q;
  logic signed [ZW-1:0] fold_z_q, fold_z_d, ang_ext;
  logic                 fold_neg;
  logic signed [SW-1:0] fold_a_q, fold_b_q;

  always_comb begin
    ang_ext = ZW'(angle_i);
    priority if (ang_ext > HALF_PI) begin
      fold_z_d = ang_ext - FULL_PI;
      fold_neg = 1'b1;
    end else if (ang_ext < -HALF_PI) begin
      fold_z_d = ang_ext + FULL_PI;
      fold_neg = 1'b1;
    end else begin
      fold_z_d = ang_ext;
      fold_neg = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_ctl_q <= '0;
    end else begin
      fold_ctl_q.valid <= start_i & ~busy_o;
      fold_ctl_q.func  <= func_i;
      fold_ctl_q.neg   <= fold_neg;
    end
  end

  always_ff @(posedge clk_i) begin
    fold_z_q <= fold_z_d;
    fold_a_q <= comp_a_i;
    fold_b_q <= comp_b_i;
  end

  // ---------------------------------------------------------------------------
  // CORDIC chain: one cell per micro-rotation. Each cell hands its rotated vector,
  // residual angle and the item's operands to the next cell every cycle. The
  // vector starts at (1/K, 0), so the chain output is (cos, sin) without a gain
  // correction multiply.
  // ---------------------------------------------------------------------------
  ctl_t                 ch_ctl [ITERATIONS+1];
  logic signed [XW-1:0] ch_x   [ITERATIONS+1];
  logic signed [XW-1:0] ch_y   [ITERATIONS+1];
  logic signed [ZW-1:0] ch_z   [ITERATIONS+1];
  logic signed [SW-1:0] ch_a   [ITERATIONS+1];
  logic signed [SW-1:0] ch_b   [ITERATIONS+1];

  assign ch_ctl[0] = fold_ctl_q;
  assign ch_x[0]   = CORDIC_GAIN;
  assign ch_y[0]   = '0;
  assign ch_z[0]   = fold_z_q;
  assign ch_a[0]   = fold_a_q;
  assign ch_b[0]   = fold_b_q;

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    ptc_cell #(
      .STEP (g),
      .SW   (SW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ch_ctl[g]),
      .x_i    (ch_x[g]),
      .y_i    (ch_y[g]),
      .z_i    (ch_z[g]),
      .a_i    (ch_a[g]),
      .b_i    (ch_b[g]),
      .ctl_o  (ch_ctl[g+1]),
      .x_o    (ch_x[g+1]),
      .y_o    (ch_y[g+1]),
      .z_o    (ch_z[g+1]),
      .a_o    (ch_a[g+1]),
      .b_o    (ch_b[g+1])
    );
  end

  // The final residual angle is not needed for the result; only its sign bit is tapped,
  // into z_last_sign, for the assertion that checks it for X.
  logic z_last_sign;
  assign z_last_sign = ch_z[ITERATIONS][ZW-1];

  // ---------------------------------------------------------------------------
  // Rotation: products, sign restore, round to nearest and clamp.
  // ---------------------------------------------------------------------------
  ptc_mix #(
    .SW (SW)
  ) u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ch_ctl[ITERATIONS]),
    .cos_i     (ch_x[ITERATIONS]),
    .sin_i     (ch_y[ITERATIONS]),
    .a_i       (ch_a[ITERATIONS]),
    .b_i       (ch_b[ITERATIONS]),
    .done_o    (done_o),
    .out_a_o   (out_a_o),
    .out_b_o   (out_b_o),
    .clipped_o (clipped_o)
  );

  localparam logic signed [SW-1:0] S_MAX = SW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] S_MIN = -S_MAX - SW'(1);

`ifndef ASSERT_OFF
  // Every done strobe traces back to an earlier start transfer.
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("done strobe without matching start transfer");

  // A clipped result sits on one of the sample bounds.
  a_clip_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clipped_o) |->
      (out_a_o == S_MAX || out_a_o == S_MIN || out_b_o == S_MAX || out_b_o == S_MIN))
    else $error("clipped flag set but no output at a bound");

  // The residual angle sign is only meaningful for live items; it must never be X there.
  a_no_x_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_ctl[ITERATIONS].valid |-> !$isunknown(z_last_sign))
    else $error("unknown residual angle in the CORDIC chain");
`endif

endmodule
